FILE: rtl/core/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types, codes and helpers of the convolution layer with relu and pooling.
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam int ADDR_W = 15;
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ACC_W  = 64;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_WR_FEAT = 3'd0,
        OP_WR_WT   = 3'd1,
        OP_WR_BIAS = 3'd2,
        OP_START   = 3'd3,
        OP_RD_OUT  = 3'd4
    } t_op;

    localparam logic [IDX_W-1:0] REG_CHANNELS = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd2;
    localparam logic [IDX_W-1:0] REG_FILTERS  = 3'd3;
    localparam logic [IDX_W-1:0] REG_KERNEL   = 3'd4;
    localparam logic [IDX_W-1:0] REG_PADDING  = 3'd5;
    localparam logic [IDX_W-1:0] REG_STRIDE   = 3'd6;
    localparam logic [IDX_W-1:0] REG_POST     = 3'd7;

    localparam logic [1:0] POOL_NONE = 2'd0;
    localparam logic [1:0] POOL_MAX  = 2'd1;
    localparam logic [1:0] POOL_AVG  = 2'd2;

    typedef struct packed {
        logic [6:0] ch;
        logic [6:0] h;
        logic [6:0] w;
        logic [7:0] f;
        logic [2:0] k;
        logic [1:0] p;
        logic [2:0] s;
        logic       relu;
        logic [1:0] pool;
    } t_cfg;

    typedef struct packed {
        logic                     valid;
        logic [OP_W-1:0]          op;
        logic [ADDR_W-1:0]        addr;
        logic signed [DATA_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic                     done;
        logic                     status;
        logic signed [DATA_W-1:0] rdata;
    } t_rsp;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } t_mac_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_SETUP0,
        ST_SETUP1,
        ST_SETUP2,
        ST_TAP,
        ST_MUL,
        ST_ACC,
        ST_PIX,
        ST_POOL,
        ST_DONE
    } t_state;

    // x / s for s in 1..4, x below 256
    function automatic logic [7:0] div_small(input logic [7:0] x, input logic [2:0] s);
        logic [16:0] m;
        begin
            m = 17'(x) * 17'd171;
            unique case (s)
                3'd2:    div_small = x >> 1;
                3'd3:    div_small = m[16:9];
                3'd4:    div_small = x >> 2;
                default: div_small = x;
            endcase
        end
    endfunction

endpackage

FILE: rtl/core/crp_mac.sv
// ----------------------------------------------------------------------------
// crp_mac
// Shared multiply-accumulate unit: registered Q32.32 product of Q16.16 operands, 64-bit Q48.16 sum.
// ----------------------------------------------------------------------------
module crp_mac (
    input  logic                                i_clk,
    input  crp_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [crp_pkg::DATA_W-1:0]   i_a,
    input  logic signed [crp_pkg::DATA_W-1:0]   i_b,
    output logic signed [crp_pkg::ACC_W-1:0]    o_acc
);

    logic signed [crp_pkg::ACC_W-1:0] r_prod;
    logic signed [crp_pkg::ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
    end

    // product >> 16 rounds toward minus infinity
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + (r_prod >>> 16);
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: rtl/core/crp_engine.sv
// ----------------------------------------------------------------------------
// crp_engine
// Stores, host access and the layer sequencer around the shared mac unit.
// ----------------------------------------------------------------------------
module crp_engine #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_DIM      = 32,
    parameter int MAX_FILTERS  = 32,
    parameter int MAX_KERNEL   = 5,
    parameter int DILATION     = 1,
    parameter int ALIGN        = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  crp_pkg::t_cfg i_cfg,
    input  crp_pkg::t_cmd i_cmd,
    output crp_pkg::t_rsp o_rsp
);

    localparam int PLANE_DIM  = MAX_DIM + 4;
    localparam int FEAT_PLANE = ((MAX_DIM * MAX_DIM + ALIGN - 1) / ALIGN) * ALIGN;
    localparam int FEAT_DEPTH = MAX_CHANNELS * FEAT_PLANE;
    localparam int WT_DEPTH   = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int RES_DEPTH  = MAX_FILTERS * FEAT_PLANE;
    localparam int PL_DEPTH   = PLANE_DIM * PLANE_DIM;
    localparam int FA_W = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
    localparam int WA_W = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
    localparam int BA_W = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int RA_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int PA_W = $clog2(PL_DEPTH);
    localparam int FX_W = $clog2(FEAT_DEPTH + MAX_DIM * MAX_DIM + MAX_DIM + 1) + 1;
    localparam int WX_W = $clog2(2 * WT_DEPTH + 1) + 1;
    localparam int OX_W = $clog2(MAX_FILTERS * (PL_DEPTH + ALIGN) + PL_DEPTH + 1) + 1;
    localparam int DW   = crp_pkg::DATA_W;
    localparam logic [32:0] ALIGN_RCP =
        33'(((64'd1 << 32) + 64'(ALIGN) - 64'd1) / 64'(ALIGN));

    // round up to a multiple of ALIGN by reciprocal multiplication
    function automatic logic [15:0] align_up(input logic [15:0] x);
        logic [16:0] xa;
        logic [49:0] prod;
        logic [17:0] q;
        xa       = 17'(x) + 17'(ALIGN - 1);
        prod     = 50'(xa) * 50'(ALIGN_RCP);
        q        = prod[49:32];
        align_up = 16'(q * 18'(ALIGN));
    endfunction

    // output side count of one axis
    function automatic logic [7:0] crate_dim(input logic [7:0] x);
        crate_dim = crp_pkg::div_small(x, i_cfg.s) + 8'd1;
    endfunction

    // stores
    logic signed [DW-1:0] feat_mem [FEAT_DEPTH];
    logic signed [DW-1:0] wt_mem   [WT_DEPTH];
    logic signed [DW-1:0] bias_mem [MAX_FILTERS];
    logic signed [DW-1:0] res_mem  [RES_DEPTH];
    logic signed [DW-1:0] plane_mem[PL_DEPTH];

    logic signed [DW-1:0] r_feat_q, r_wt_q, r_bias_q, r_res_q, r_plane_q;

    crp_pkg::t_state r_state, n_state;

    // derived sizes
    logic [5:0]  r_kk;
    logic [13:0] r_hw;
    logic [7:0]  r_span;
    logic [7:0]  r_oh, r_ow;
    logic [12:0] r_fsz;
    logic [15:0] r_chan, r_ocs, r_pcs;

    // loop state
    logic [7:0]        r_f, r_r, r_c;
    logic [6:0]        r_ch;
    logic [2:0]        r_kr, r_kc;
    logic [12:0]       r_k;
    logic signed [9:0] r_irb, r_icb, r_ir, r_ic;
    logic [FX_W-1:0]   r_chbase;
    logic [WX_W-1:0]   r_wbase;
    logic [OX_W-1:0]   r_obase, r_pbase;
    logic [PA_W-1:0]   r_pix, r_prow, r_pout;
    logic [7:0]        r_pi, r_pj;
    logic [2:0]        r_pe;
    logic signed [DW-1:0] r_pmax;
    logic signed [DW+1:0] r_psum;
    logic              r_status;
    logic signed [DW-1:0] r_rdata;

    // combinational
    logic [7:0]  hp, wp, span;
    logic        host_go, feat_ok, wt_ok, bias_ok, res_ok;
    logic        tap_in, tap_ok, kc_last, kr_last, ch_last, tap_last;
    logic [FX_W-1:0] fi;
    logic [WX_W-1:0] wi;
    logic        c_last, r_last, f_last, pool_on, plane_end;
    logic signed [9:0] n_irb, n_icb;
    logic signed [crp_pkg::ACC_W-1:0] acc, sum64;
    logic signed [DW-1:0] pix_val, pool_val, pmax_n;
    logic signed [DW+1:0] psum_n;
    logic [PA_W-1:0] paddr;
    logic [7:0]  pj_n;
    logic        win_row_end, win_last;
    logic        res_we;
    logic [OX_W-1:0] res_wx;
    logic signed [DW-1:0] res_wd;
    crp_pkg::t_mac_ctl mac_ctl;

    crp_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (r_feat_q),
        .i_b   (r_wt_q),
        .o_acc (acc)
    );

    assign host_go = (r_state == crp_pkg::ST_IDLE) && i_cmd.valid;
    assign feat_ok = 32'(i_cmd.addr) < 32'(FEAT_DEPTH);
    assign wt_ok   = 32'(i_cmd.addr) < 32'(WT_DEPTH);
    assign bias_ok = 32'(i_cmd.addr) < 32'(MAX_FILTERS);
    assign res_ok  = 32'(i_cmd.addr) < 32'(RES_DEPTH);

    assign hp   = 8'(i_cfg.h) + 8'({i_cfg.p, 1'b0});
    assign wp   = 8'(i_cfg.w) + 8'({i_cfg.p, 1'b0});
    assign span = 8'(DILATION * (32'(i_cfg.k) - 1) + 1);

    // tap addressing
    assign tap_in = (r_ir >= 0) && (r_ir < $signed({3'b0, i_cfg.h}))
                 && (r_ic >= 0) && (r_ic < $signed({3'b0, i_cfg.w}));
    assign fi = r_chbase + FX_W'(r_ir[6:0] * i_cfg.w) + FX_W'(r_ic[6:0]);
    assign wi = r_wbase + WX_W'(r_k);
    assign tap_ok = tap_in && (32'(fi) < 32'(FEAT_DEPTH)) && (32'(wi) < 32'(WT_DEPTH));
    assign kc_last  = (r_kc == i_cfg.k - 3'd1);
    assign kr_last  = (r_kr == i_cfg.k - 3'd1);
    assign ch_last  = (r_ch == i_cfg.ch - 7'd1);
    assign tap_last = kc_last && kr_last && ch_last;

    // pixel and filter walk
    assign c_last    = (r_c == r_ow - 8'd1);
    assign r_last    = (r_r == r_oh - 8'd1);
    assign f_last    = (r_f == i_cfg.f - 8'd1);
    assign pool_on   = (i_cfg.pool != crp_pkg::POOL_NONE) && (r_oh >= 8'd2) && (r_ow >= 8'd2);
    assign plane_end = c_last && r_last;
    assign n_icb = c_last ? -$signed({8'b0, i_cfg.p}) : r_icb + $signed({7'b0, i_cfg.s});
    assign n_irb = !c_last ? r_irb
                 : (r_last ? -$signed({8'b0, i_cfg.p}) : r_irb + $signed({7'b0, i_cfg.s}));

    always_comb begin
        sum64 = acc + crp_pkg::ACC_W'(r_bias_q);
        if (sum64 > 64'sd2147483647) begin
            pix_val = 32'sh7fffffff;
        end else if (sum64 < -64'sd2147483648) begin
            pix_val = 32'sh80000000;
        end else begin
            pix_val = sum64[DW-1:0];
        end
        if (i_cfg.relu && pix_val < 0) begin
            pix_val = '0;
        end
    end

    // pooling window
    always_comb begin
        unique case (r_pe)
            3'd0:    paddr = r_prow + PA_W'(r_pj);
            3'd1:    paddr = r_prow + PA_W'(r_pj) + PA_W'(r_ow);
            3'd2:    paddr = r_prow + PA_W'(r_pj) + PA_W'(1);
            default: paddr = r_prow + PA_W'(r_pj) + PA_W'(r_ow) + PA_W'(1);
        endcase
        pmax_n = (r_pe == 3'd1 || r_plane_q > r_pmax) ? r_plane_q : r_pmax;
        psum_n = (r_pe == 3'd1) ? (DW+2)'(r_plane_q) : r_psum + (DW+2)'(r_plane_q);
        pool_val = (i_cfg.pool == crp_pkg::POOL_MAX) ? pmax_n : DW'(psum_n >>> 2);
    end

    assign pj_n        = r_pj + 8'd2;
    assign win_row_end = !((pj_n + 8'd1) < r_ow);
    assign win_last    = win_row_end && !((r_pi + 8'd3) < r_oh);

    // result store write port
    always_comb begin
        res_we = 1'b0;
        res_wx = r_obase + OX_W'(r_pix);
        res_wd = pix_val;
        if (r_state == crp_pkg::ST_PIX) begin
            res_we = 1'b1;
        end else if (r_state == crp_pkg::ST_POOL && r_pe == 3'd4) begin
            res_we = 1'b1;
            res_wx = r_pbase + OX_W'(r_pout);
            res_wd = pool_val;
        end
        if (!(32'(res_wx) < 32'(RES_DEPTH))) begin
            res_we = 1'b0;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (host_go && i_cmd.op == crp_pkg::OP_WR_FEAT && feat_ok) begin
            feat_mem[FA_W'(i_cmd.addr)] <= i_cmd.data;
        end
        r_feat_q <= feat_mem[fi[FA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (host_go && i_cmd.op == crp_pkg::OP_WR_WT && wt_ok) begin
            wt_mem[WA_W'(i_cmd.addr)] <= i_cmd.data;
        end
        r_wt_q <= wt_mem[wi[WA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (host_go && i_cmd.op == crp_pkg::OP_WR_BIAS && bias_ok) begin
            bias_mem[BA_W'(i_cmd.addr)] <= i_cmd.data;
        end
        r_bias_q <= bias_mem[r_f[BA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            res_mem[res_wx[RA_W-1:0]] <= res_wd;
        end
        r_res_q <= res_mem[RA_W'(i_cmd.addr)];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == crp_pkg::ST_PIX) begin
            plane_mem[r_pix] <= pix_val;
        end
        r_plane_q <= plane_mem[paddr];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and mac control
    always_comb begin
        n_state = r_state;
        mac_ctl = '0;
        unique case (r_state)
            crp_pkg::ST_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.op)
                        crp_pkg::OP_START:  n_state = crp_pkg::ST_SETUP0;
                        crp_pkg::OP_RD_OUT: n_state = res_ok ? crp_pkg::ST_RD
                                                             : crp_pkg::ST_DONE;
                        default:            n_state = crp_pkg::ST_DONE;
                    endcase
                end
            end
            crp_pkg::ST_RD:     n_state = crp_pkg::ST_DONE;
            crp_pkg::ST_SETUP0: n_state = crp_pkg::ST_SETUP1;
            crp_pkg::ST_SETUP1: n_state = crp_pkg::ST_SETUP2;
            crp_pkg::ST_SETUP2: begin
                mac_ctl.clear = 1'b1;
                n_state = (r_oh == 8'd0 || r_ow == 8'd0) ? crp_pkg::ST_DONE
                                                         : crp_pkg::ST_TAP;
            end
            crp_pkg::ST_TAP: begin
                priority if (tap_ok) begin
                    n_state = crp_pkg::ST_MUL;
                end else if (tap_last) begin
                    n_state = crp_pkg::ST_PIX;
                end else begin
                    n_state = crp_pkg::ST_TAP;
                end
            end
            crp_pkg::ST_MUL: begin
                mac_ctl.mul_en = 1'b1;
                n_state = crp_pkg::ST_ACC;
            end
            crp_pkg::ST_ACC: begin
                mac_ctl.acc_en = 1'b1;
                n_state = tap_last ? crp_pkg::ST_PIX : crp_pkg::ST_TAP;
            end
            crp_pkg::ST_PIX: begin
                mac_ctl.clear = 1'b1;
                priority if (!plane_end) begin
                    n_state = crp_pkg::ST_TAP;
                end else if (pool_on) begin
                    n_state = crp_pkg::ST_POOL;
                end else if (f_last) begin
                    n_state = crp_pkg::ST_DONE;
                end else begin
                    n_state = crp_pkg::ST_TAP;
                end
            end
            crp_pkg::ST_POOL: begin
                if (r_pe == 3'd4 && win_last) begin
                    n_state = f_last ? crp_pkg::ST_DONE : crp_pkg::ST_TAP;
                end
            end
            crp_pkg::ST_DONE:   n_state = crp_pkg::ST_IDLE;
            default:            n_state = crp_pkg::ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            crp_pkg::ST_IDLE: begin
                r_rdata  <= '0;
                r_status <= 1'b0;
                if (i_cmd.valid) begin
                    unique case (i_cmd.op)
                        crp_pkg::OP_WR_FEAT: r_status <= !feat_ok;
                        crp_pkg::OP_WR_WT:   r_status <= !wt_ok;
                        crp_pkg::OP_WR_BIAS: r_status <= !bias_ok;
                        crp_pkg::OP_START:   r_status <= 1'b0;
                        crp_pkg::OP_RD_OUT:  r_status <= !res_ok;
                        default:             r_status <= 1'b1;
                    endcase
                end
            end
            crp_pkg::ST_RD: begin
                r_rdata <= r_res_q;
            end
            crp_pkg::ST_SETUP0: begin
                r_kk   <= 6'(i_cfg.k * i_cfg.k);
                r_hw   <= 14'(i_cfg.h * i_cfg.w);
                r_span <= span;
            end
            crp_pkg::ST_SETUP1: begin
                r_oh   <= (hp >= r_span) ? crate_dim(hp - r_span) : 8'd0;
                r_ow   <= (wp >= r_span) ? crate_dim(wp - r_span) : 8'd0;
                r_fsz  <= 13'(i_cfg.ch * r_kk);
                r_chan <= align_up(16'(r_hw));
            end
            crp_pkg::ST_SETUP2: begin
                r_ocs    <= align_up(16'(r_oh * r_ow));
                r_pcs    <= align_up(16'((r_oh >> 1) * (r_ow >> 1)));
                r_f      <= '0;
                r_r      <= '0;
                r_c      <= '0;
                r_ch     <= '0;
                r_kr     <= '0;
                r_kc     <= '0;
                r_k      <= '0;
                r_irb    <= -$signed({8'b0, i_cfg.p});
                r_icb    <= -$signed({8'b0, i_cfg.p});
                r_ir     <= -$signed({8'b0, i_cfg.p});
                r_ic     <= -$signed({8'b0, i_cfg.p});
                r_chbase <= '0;
                r_wbase  <= '0;
                r_obase  <= '0;
                r_pbase  <= '0;
                r_pix    <= '0;
            end
            crp_pkg::ST_TAP, crp_pkg::ST_ACC: begin
                if (!(r_state == crp_pkg::ST_TAP && tap_ok)) begin
                    r_k <= r_k + 13'd1;
                    if (kc_last) begin
                        r_kc <= '0;
                        r_ic <= r_icb;
                        if (kr_last) begin
                            r_kr     <= '0;
                            r_ir     <= r_irb;
                            r_ch     <= r_ch + 7'd1;
                            r_chbase <= r_chbase + FX_W'(r_chan);
                        end else begin
                            r_kr <= r_kr + 3'd1;
                            r_ir <= r_ir + 10'(DILATION);
                        end
                    end else begin
                        r_kc <= r_kc + 3'd1;
                        r_ic <= r_ic + 10'(DILATION);
                    end
                end
            end
            crp_pkg::ST_PIX: begin
                r_ch     <= '0;
                r_kr     <= '0;
                r_kc     <= '0;
                r_k      <= '0;
                r_chbase <= '0;
                r_irb    <= n_irb;
                r_icb    <= n_icb;
                r_ir     <= n_irb;
                r_ic     <= n_icb;
                r_pe     <= '0;
                r_pi     <= '0;
                r_pj     <= '0;
                r_prow   <= '0;
                r_pout   <= '0;
                if (c_last) begin
                    r_c <= '0;
                    r_r <= r_last ? 8'd0 : r_r + 8'd1;
                end else begin
                    r_c <= r_c + 8'd1;
                end
                if (plane_end) begin
                    r_pix <= '0;
                    if (!pool_on) begin
                        r_f     <= r_f + 8'd1;
                        r_wbase <= r_wbase + WX_W'(r_fsz);
                        r_obase <= r_obase + OX_W'(r_ocs);
                        r_pbase <= r_pbase + OX_W'(r_pcs);
                    end
                end else begin
                    r_pix <= r_pix + PA_W'(1);
                end
            end
            crp_pkg::ST_POOL: begin
                r_pmax <= pmax_n;
                r_psum <= psum_n;
                if (r_pe == 3'd4) begin
                    r_pe   <= '0;
                    r_pout <= r_pout + PA_W'(1);
                    if (win_row_end) begin
                        r_pj   <= '0;
                        r_pi   <= r_pi + 8'd2;
                        r_prow <= r_prow + PA_W'({r_ow, 1'b0});
                    end else begin
                        r_pj <= pj_n;
                    end
                    if (win_last) begin
                        r_f     <= r_f + 8'd1;
                        r_wbase <= r_wbase + WX_W'(r_fsz);
                        r_obase <= r_obase + OX_W'(r_ocs);
                        r_pbase <= r_pbase + OX_W'(r_pcs);
                    end
                end else begin
                    r_pe <= r_pe + 3'd1;
                end
            end
            default: begin
                r_rdata <= r_rdata;
            end
        endcase
    end

    assign o_rsp.done   = (r_state == crp_pkg::ST_DONE);
    assign o_rsp.status = r_status;
    assign o_rsp.rdata  = r_rdata;

endmodule

FILE: rtl/core/conv2d_relu_pool_layer_top.sv
// ----------------------------------------------------------------------------
// conv2d_relu_pool_layer_top
// Convolution layer with bias, relu and 2x2 pooling on Q16.16 words.
//
//  channel   dir   payload                                     
//  s_axis    in    tuser: op[2:0]; tdata: addr[14:0], data_in[46:15]
//  m_axis    out   tuser: status[0]; tdata: read_data[31:0]
//  cfg       in    i_cfg_we, i_cfg_idx (register), i_cfg_data
//
//  write, bad-address and unknown items: done state, then registered result
//  read item: read state (registered result store read), done state, registered result
//  start item: tap, mul and acc states per in-bounds tap, tap state per padded tap,
//    pixel state per pixel and pooling state per window, all on the one shared mac unit
//  a new item is taken once the previous result has been taken on m_axis
//  synchronous active-low reset restores the register defaults; stores are not cleared
// ----------------------------------------------------------------------------
module conv2d_relu_pool_layer_top #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_DIM      = 32,
    parameter int MAX_FILTERS  = 32,
    parameter int MAX_KERNEL   = 5,
    parameter int DILATION     = 1,
    parameter int ALIGN        = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [47:0]                   s_axis_tdata,   // addr, data_in, zero pad
    input  logic [2:0]                    s_axis_tuser,   // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,   // read_data
    output logic [0:0]                    m_axis_tuser,   // status
    input  logic                          i_cfg_we,
    input  logic [crp_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [crp_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [4:0] r_ch_reg;
    logic [5:0] r_h_reg, r_w_reg, r_f_reg;
    logic [2:0] r_k_reg, r_s_reg, r_post_reg;
    logic [1:0] r_p_reg;
    logic       r_busy, r_ovalid, r_ostatus;
    logic [31:0] r_odata;
    logic       in_acc;
    crp_pkg::t_cfg cfg;
    crp_pkg::t_cmd cmd;
    crp_pkg::t_rsp rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_reg   <= 5'd1;
            r_h_reg    <= 6'd32;
            r_w_reg    <= 6'd32;
            r_f_reg    <= 6'd1;
            r_k_reg    <= 3'd3;
            r_p_reg    <= 2'd1;
            r_s_reg    <= 3'd1;
            r_post_reg <= 3'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                crp_pkg::REG_CHANNELS: r_ch_reg   <= i_cfg_data[4:0];
                crp_pkg::REG_HEIGHT:   r_h_reg    <= i_cfg_data[5:0];
                crp_pkg::REG_WIDTH:    r_w_reg    <= i_cfg_data[5:0];
                crp_pkg::REG_FILTERS:  r_f_reg    <= i_cfg_data[5:0];
                crp_pkg::REG_KERNEL:   r_k_reg    <= i_cfg_data[2:0];
                crp_pkg::REG_PADDING:  r_p_reg    <= i_cfg_data[1:0];
                crp_pkg::REG_STRIDE:   r_s_reg    <= i_cfg_data[2:0];
                default:               r_post_reg <= i_cfg_data[2:0];
            endcase
        end
    end

    // clamp registers to the supported ranges
    always_comb begin
        cfg.ch   = (r_ch_reg == 5'd0) ? 7'd1
                 : (32'(r_ch_reg) > MAX_CHANNELS) ? 7'(MAX_CHANNELS) : 7'(r_ch_reg);
        cfg.h    = (r_h_reg == 6'd0) ? 7'd1
                 : (32'(r_h_reg) > MAX_DIM) ? 7'(MAX_DIM) : 7'(r_h_reg);
        cfg.w    = (r_w_reg == 6'd0) ? 7'd1
                 : (32'(r_w_reg) > MAX_DIM) ? 7'(MAX_DIM) : 7'(r_w_reg);
        cfg.f    = (r_f_reg == 6'd0) ? 8'd1
                 : (32'(r_f_reg) > MAX_FILTERS) ? 8'(MAX_FILTERS) : 8'(r_f_reg);
        cfg.k    = (r_k_reg == 3'd0) ? 3'd1
                 : (32'(r_k_reg) > MAX_KERNEL) ? 3'(MAX_KERNEL) : r_k_reg;
        cfg.p    = (r_p_reg > 2'd2) ? 2'd2 : r_p_reg;
        cfg.s    = (r_s_reg == 3'd0) ? 3'd1 : (r_s_reg > 3'd4) ? 3'd4 : r_s_reg;
        cfg.relu = r_post_reg[0];
        cfg.pool = (r_post_reg[2:1] == 2'd3) ? crp_pkg::POOL_AVG : r_post_reg[2:1];
    end

    assign s_axis_tready = !r_busy && !r_ovalid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign cmd.valid = in_acc;
    assign cmd.op    = s_axis_tuser;
    assign cmd.addr  = s_axis_tdata[14:0];
    assign cmd.data  = s_axis_tdata[46:15];

    crp_engine #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_DIM      (MAX_DIM),
        .MAX_FILTERS  (MAX_FILTERS),
        .MAX_KERNEL   (MAX_KERNEL),
        .DILATION     (DILATION),
        .ALIGN        (ALIGN)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (rsp.done) begin
                r_busy <= 1'b0;
            end
            if (rsp.done) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp.done) begin
            r_odata   <= rsp.rdata;
            r_ostatus <= rsp.status;
        end
    end

    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = r_odata;
    assign m_axis_tuser[0] = r_ostatus;

endmodule

FILE: sim/tb_conv2d_relu_pool_layer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_relu_pool_layer_top
// Self-checking bench for the convolution layer with relu and 2x2 pooling.
// Items are loaded into the feature, weight and bias stores, start runs the
// layer and result words are read back. Every result item is compared against
// a bit-exact Q16.16 layer calculation kept in the bench, across several
// layer shapes, clamped register values and random traffic with idling on
// both streams.
// ----------------------------------------------------------------------------
module tb_conv2d_relu_pool_layer_top;

    localparam int FEAT_DEPTH  = 16384;
    localparam int WT_DEPTH    = 12800;
    localparam int BIAS_DEPTH  = 32;
    localparam int RES_DEPTH   = 32768;
    localparam int PLANE_W     = 36;
    localparam int ITEM_TARGET = 950;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [31:0] rdata;
        logic        status;
    } t_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // addr[14:0], data_in[46:15], zero
    logic [2:0]  s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // read_data
    logic [0:0]  m_axis_tuser;   // status
    logic        i_cfg_we;
    logic [crp_pkg::IDX_W-1:0] i_cfg_idx;
    logic [crp_pkg::CFG_W-1:0] i_cfg_data;

    conv2d_relu_pool_layer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    int  feat_mem [FEAT_DEPTH];
    int  wt_mem   [WT_DEPTH];
    int  bias_mem [BIAS_DEPTH];
    int  res_mem  [RES_DEPTH];
    bit  res_seen [RES_DEPTH];
    int  conv_plane [PLANE_W*PLANE_W];
    int  layer_regs [8];
    int  res_addrs[$];
    int  run_addrs[$];
    t_word pending_words[$];

    int  items_sent;
    int  errors;
    int  cycle_cnt;
    int  rx_hold;
    bit  tx_calm;
    bit  rx_calm;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic int clamp_reg(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int round_even(longint x);
        return int'(((x + 1) / 2) * 2);
    endfunction

    function automatic void store_result(longint idx, int v);
        if (idx >= 0 && idx < RES_DEPTH) begin
            res_mem[idx] = v;
            run_addrs.push_back(int'(idx));
            if (!res_seen[idx]) begin
                res_seen[idx] = 1'b1;
                res_addrs.push_back(int'(idx));
            end
        end
    endfunction

    function automatic int pool_window(int a, int b, int c, int d, int mode);
        int m;
        longint s;
        if (mode == crp_pkg::POOL_MAX) begin
            m = a;
            if (b > m) m = b;
            if (c > m) m = c;
            if (d > m) m = d;
            return m;
        end
        s = longint'(a) + b + c + d;
        return int'(s >>> 2);
    endfunction

    function automatic void run_conv_layer();
        int nc, nh, nw, nf, nk, np, ns, pool, oh, ow;
        int f, r, c, ch, kr, kc, ir, ic, i, j, v;
        bit relu;
        longint acc, chan, fsz, ocs, pcs, kidx, fi, wi;
        nc = clamp_reg(layer_regs[crp_pkg::REG_CHANNELS], 1, 16);
        nh = clamp_reg(layer_regs[crp_pkg::REG_HEIGHT], 1, 32);
        nw = clamp_reg(layer_regs[crp_pkg::REG_WIDTH], 1, 32);
        nf = clamp_reg(layer_regs[crp_pkg::REG_FILTERS], 1, 32);
        nk = clamp_reg(layer_regs[crp_pkg::REG_KERNEL], 1, 5);
        np = clamp_reg(layer_regs[crp_pkg::REG_PADDING], 0, 2);
        ns = clamp_reg(layer_regs[crp_pkg::REG_STRIDE], 1, 4);
        relu = layer_regs[crp_pkg::REG_POST][0];
        pool = (layer_regs[crp_pkg::REG_POST] >> 1) & 3;
        if (pool == 3) pool = crp_pkg::POOL_AVG;
        oh = (nh + 2*np >= nk) ? (nh + 2*np - nk) / ns + 1 : 0;
        ow = (nw + 2*np >= nk) ? (nw + 2*np - nk) / ns + 1 : 0;
        chan = round_even(longint'(nh) * nw);
        fsz = longint'(nc) * nk * nk;
        ocs = round_even(longint'(oh) * ow);
        pcs = round_even(longint'(oh / 2) * (ow / 2));
        run_addrs.delete();
        for (f = 0; f < nf; f++) begin
            for (r = 0; r < oh; r++) begin
                for (c = 0; c < ow; c++) begin
                    acc = 0;
                    kidx = 0;
                    for (ch = 0; ch < nc; ch++) begin
                        for (kr = 0; kr < nk; kr++) begin
                            for (kc = 0; kc < nk; kc++) begin
                                ir = r*ns - np + kr;
                                ic = c*ns - np + kc;
                                if (ir >= 0 && ir < nh && ic >= 0 && ic < nw) begin
                                    fi = ch*chan + longint'(ir)*nw + ic;
                                    wi = f*fsz + kidx;
                                    if (fi < FEAT_DEPTH && wi < WT_DEPTH)
                                        acc += (longint'(feat_mem[fi]) *
                                                longint'(wt_mem[wi])) >>> 16;
                                end
                                kidx++;
                            end
                        end
                    end
                    acc += bias_mem[f];
                    if (acc > 64'sd2147483647) v = 32'h7fffffff;
                    else if (acc < -64'sd2147483648) v = 32'h80000000;
                    else v = int'(acc);
                    if (relu && v < 0) v = 0;
                    conv_plane[r*ow + c] = v;
                    store_result(f*ocs + longint'(r)*ow + c, v);
                end
            end
            if (pool != crp_pkg::POOL_NONE) begin
                for (i = 0; i + 1 < oh; i += 2)
                    for (j = 0; j + 1 < ow; j += 2)
                        store_result(f*pcs + longint'(i/2)*(ow/2) + j/2,
                            pool_window(conv_plane[i*ow + j], conv_plane[(i+1)*ow + j],
                                        conv_plane[i*ow + j + 1],
                                        conv_plane[(i+1)*ow + j + 1], pool));
            end
        end
    endfunction

    function automatic t_word predict_item(logic [2:0] op, logic [14:0] addr,
                                           logic [31:0] data);
        t_word w;
        w.rdata = '0;
        w.status = 1'b0;
        case (op)
            crp_pkg::OP_WR_FEAT:
                if (addr < FEAT_DEPTH) feat_mem[addr] = data; else w.status = 1'b1;
            crp_pkg::OP_WR_WT:
                if (addr < WT_DEPTH) wt_mem[addr] = data; else w.status = 1'b1;
            crp_pkg::OP_WR_BIAS:
                if (addr < BIAS_DEPTH) bias_mem[addr] = data; else w.status = 1'b1;
            crp_pkg::OP_START:
                run_conv_layer();
            crp_pkg::OP_RD_OUT:
                if (addr < RES_DEPTH) w.rdata = res_mem[addr]; else w.status = 1'b1;
            default:
                w.status = 1'b1;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
            default: return $urandom_range(0, 1 << 19) - (1 << 18);
        endcase
    endfunction

    // result side: checking and stall
    always @(posedge i_clk) begin
        t_word want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: data %h status %0d", m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_words.pop_front();
                if (m_axis_tdata !== want.rdata || m_axis_tuser[0] !== want.status) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected data %h status %0d, got data %h status %0d",
                                 want.rdata, want.status, m_axis_tdata, m_axis_tuser);
                end
            end
            rx_hold = rx_calm ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready = (rx_hold == 0);
        if (rx_hold > 0) rx_hold--;
    end

    task automatic send_item(logic [2:0] op, logic [14:0] addr, logic [31:0] data);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser = op;
        s_axis_tdata = {1'b0, data, addr};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_words.push_back(predict_item(op, addr, data));
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [crp_pkg::IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val[crp_pkg::CFG_W-1:0];
        layer_regs[idx] = val & ((idx == crp_pkg::REG_CHANNELS) ? 31 :
                                 (idx <= crp_pkg::REG_FILTERS) ? 63 :
                                 (idx == crp_pkg::REG_PADDING) ? 3 : 7);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_layer(int nc, int nh, int nw, int nf, int nk, int np, int ns, int post);
        wait_drained();
        write_reg(crp_pkg::REG_CHANNELS, nc);
        write_reg(crp_pkg::REG_HEIGHT, nh);
        write_reg(crp_pkg::REG_WIDTH, nw);
        write_reg(crp_pkg::REG_FILTERS, nf);
        write_reg(crp_pkg::REG_KERNEL, nk);
        write_reg(crp_pkg::REG_PADDING, np);
        write_reg(crp_pkg::REG_STRIDE, ns);
        write_reg(crp_pkg::REG_POST, post);
    endtask

    // fill every word that the next start will read
    task automatic load_layer();
        int nc, nh, nw, nf, nk, chan, i, c;
        nc = clamp_reg(layer_regs[crp_pkg::REG_CHANNELS], 1, 16);
        nh = clamp_reg(layer_regs[crp_pkg::REG_HEIGHT], 1, 32);
        nw = clamp_reg(layer_regs[crp_pkg::REG_WIDTH], 1, 32);
        nf = clamp_reg(layer_regs[crp_pkg::REG_FILTERS], 1, 32);
        nk = clamp_reg(layer_regs[crp_pkg::REG_KERNEL], 1, 5);
        chan = round_even(nh * nw);
        for (c = 0; c < nc; c++)
            for (i = 0; i < nh * nw; i++)
                send_item(crp_pkg::OP_WR_FEAT, 15'(c * chan + i), rand_q());
        for (i = 0; i < nf * nc * nk * nk; i++)
            send_item(crp_pkg::OP_WR_WT, 15'(i), rand_q());
        for (i = 0; i < nf; i++)
            send_item(crp_pkg::OP_WR_BIAS, 15'(i), rand_q());
    endtask

    task automatic run_and_read(int max_reads);
        int addrs[$];
        int i;
        send_item(crp_pkg::OP_START, 15'($urandom), $urandom);
        addrs = run_addrs;
        if (addrs.size() <= max_reads) begin
            for (i = 0; i < addrs.size(); i++)
                send_item(crp_pkg::OP_RD_OUT, 15'(addrs[i]), $urandom);
        end else begin
            for (i = 0; i < max_reads; i++)
                send_item(crp_pkg::OP_RD_OUT,
                          15'(addrs[$urandom_range(0, addrs.size() - 1)]), $urandom);
        end
    endtask

    task automatic test_access_ops();
        logic [2:0] op;
        send_item(crp_pkg::OP_WR_FEAT, 15'd0, 32'h80000000);
        send_item(crp_pkg::OP_WR_FEAT, 15'(FEAT_DEPTH - 1), 32'h7fffffff);
        send_item(crp_pkg::OP_WR_FEAT, 15'(FEAT_DEPTH), 32'hffffffff);
        send_item(crp_pkg::OP_WR_FEAT, 15'h7fff, 32'h00000000);
        send_item(crp_pkg::OP_WR_WT, 15'(WT_DEPTH - 1), 32'h55555555);
        send_item(crp_pkg::OP_WR_WT, 15'(WT_DEPTH), 32'haaaaaaaa);
        send_item(crp_pkg::OP_WR_BIAS, 15'(BIAS_DEPTH - 1), 32'h00010000);
        send_item(crp_pkg::OP_WR_BIAS, 15'(BIAS_DEPTH), 32'hffff0000);
        for (op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST && op >= OP_UNUSED_FIRST; op++)
            send_item(op, 15'($urandom), $urandom);
    endtask

    task automatic test_layer_shapes();
        // relu, plain
        set_layer(1, 5, 5, 2, 3, 1, 1, 1);
        load_layer();
        run_and_read(60);
        // max pooling with an odd column count, stride two
        set_layer(2, 6, 7, 1, 3, 0, 2, 2);
        load_layer();
        run_and_read(40);
        // average pooling, widest kernel and padding
        set_layer(1, 4, 4, 1, 5, 2, 1, 4);
        load_layer();
        run_and_read(40);
        // channels above range, pool code three
        set_layer(63, 2, 2, 1, 1, 0, 1, 6);
        load_layer();
        run_and_read(40);
        // tallest map, one column, so no pooling window
        set_layer(1, 32, 1, 1, 1, 0, 4, 3);
        load_layer();
        run_and_read(40);
        // widest map, all filters, padding and stride above range
        set_layer(1, 1, 32, 32, 2, 3, 7, 5);
        load_layer();
        run_and_read(48);
        // zero registers act as their low bounds, kernel wider than the map
        set_layer(0, 0, 1, 0, 7, 0, 0, 0);
        load_layer();
        run_and_read(10);
        set_layer(3, 3, 3, 2, 2, 1, 3, 3);
        load_layer();
        run_and_read(40);
    endtask

    task automatic test_random_traffic();
        int n, i, pick;
        while (items_sent < ITEM_TARGET) begin
            set_layer($urandom_range(0, 3), $urandom_range(0, 8), $urandom_range(0, 8),
                      $urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 3),
                      $urandom_range(0, 7), $urandom_range(0, 7));
            tx_calm = ($urandom_range(0, 3) == 0);
            load_layer();
            send_item(crp_pkg::OP_START, 15'($urandom), $urandom);
            n = $urandom_range(20, 60);
            for (i = 0; i < n; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50 && res_addrs.size() != 0)
                    send_item(crp_pkg::OP_RD_OUT,
                              15'(res_addrs[$urandom_range(0, res_addrs.size() - 1)]),
                              $urandom);
                else if (pick < 62)
                    send_item(crp_pkg::OP_WR_FEAT,
                              15'($urandom_range(0, FEAT_DEPTH - 1)), rand_q());
                else if (pick < 70)
                    send_item(crp_pkg::OP_WR_WT,
                              15'($urandom_range(0, WT_DEPTH - 1)), rand_q());
                else if (pick < 74)
                    send_item(crp_pkg::OP_WR_BIAS,
                              15'($urandom_range(0, BIAS_DEPTH - 1)), rand_q());
                else if (pick < 78)
                    send_item(crp_pkg::OP_WR_FEAT,
                              15'($urandom_range(FEAT_DEPTH, 32767)), $urandom);
                else if (pick < 81)
                    send_item(crp_pkg::OP_WR_WT,
                              15'($urandom_range(WT_DEPTH, 32767)), $urandom);
                else if (pick < 84)
                    send_item(crp_pkg::OP_WR_BIAS,
                              15'($urandom_range(BIAS_DEPTH, 32767)), $urandom);
                else if (pick < 90)
                    send_item(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                              15'($urandom), $urandom);
                else
                    send_item(crp_pkg::OP_START, 15'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        items_sent = 0;
        errors = 0;
        cycle_cnt = 0;
        rx_hold = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        layer_regs = '{1, 32, 32, 1, 3, 1, 1, 0};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_access_ops();
        test_layer_shapes();
        test_random_traffic();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
